// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the literal parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ilp_pkg.sv =====
// Package with the types, constants and helper functions of the literal parser.
package ilp_pkg;

    localparam int CharWidth         = 8;
    localparam int AccWidth          = 64;
    localparam int ResultWidth       = 64;
    localparam int ValueWidthDefault = 64;
    localparam int NarrowWidth       = 32;

    localparam logic [AccWidth-1:0] NarrowMask = 64'h0000_0000_FFFF_FFFF;

    // Characters with a meaning of their own in a literal.
    localparam logic [CharWidth-1:0] CharPlus       = 8'h2B;
    localparam logic [CharWidth-1:0] CharMinus      = 8'h2D;
    localparam logic [CharWidth-1:0] CharZero       = 8'h30;
    localparam logic [CharWidth-1:0] CharNine       = 8'h39;
    localparam logic [CharWidth-1:0] CharUpperA     = 8'h41;
    localparam logic [CharWidth-1:0] CharUpperF     = 8'h46;
    localparam logic [CharWidth-1:0] CharUnderscore = 8'h5F;
    localparam logic [CharWidth-1:0] CharLowerA     = 8'h61;
    localparam logic [CharWidth-1:0] CharLowerB     = 8'h62;
    localparam logic [CharWidth-1:0] CharLowerF     = 8'h66;
    localparam logic [CharWidth-1:0] CharLowerO     = 8'h6F;
    localparam logic [CharWidth-1:0] CharLowerX     = 8'h78;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_LEAD_ZERO,
        PH_NEED_DIGIT,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_BIN,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    // Running state of the literal being parsed.
    typedef struct packed {
        phase_t              phase;
        radix_t              radix;
        logic                minus;
        logic [AccWidth-1:0] acc;
        logic                err;
        logic                wrap;
    } parse_state_t;

    // Summary of a finished literal, handed to the result formatting.
    typedef struct packed {
        logic                ok;
        radix_t              radix;
        logic                minus;
        logic                wrap;
        logic [AccWidth-1:0] mag;
    } parse_done_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] val;
    } digit_t;

    localparam parse_state_t ParseIdle = '{
        phase: PH_START,
        radix: RADIX_DEC,
        minus: 1'b0,
        acc:   '0,
        err:   1'b0,
        wrap:  1'b0
    };

    // Value of a decimal or hexadecimal digit of either case.
    function automatic digit_t digit_of(input logic [CharWidth-1:0] c);
        digit_t d;
        d.hit = 1'b1;
        d.val = 4'd0;
        case (c) inside
            [CharZero:CharNine]:     d.val = 4'(c - CharZero);
            [CharLowerA:CharLowerF]: d.val = 4'(c - CharLowerA) + 4'd10;
            [CharUpperA:CharUpperF]: d.val = 4'(c - CharUpperA) + 4'd10;
            default:                 d.hit = 1'b0;
        endcase
        return d;
    endfunction

    // One more than the largest digit of a radix.
    function automatic logic [4:0] radix_limit(input radix_t r);
        logic [4:0] lim;
        case (r)
            RADIX_DEC: lim = 5'd10;
            RADIX_BIN: lim = 5'd2;
            RADIX_OCT: lim = 5'd8;
            RADIX_HEX: lim = 5'd16;
            default:   lim = 5'd10;
        endcase
        return lim;
    endfunction

endpackage

// ===== sv/ilp_in_if.sv =====
// Channel that carries the characters of a literal into the parser.
interface ilp_in_if;
    import ilp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CharWidth-1:0] char_code;
    logic                 last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== sv/ilp_out_if.sv =====
// Channel that carries the converted literal out of the parser.
interface ilp_out_if;
    import ilp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ResultWidth-1:0] value;
    logic                   is_valid;
    logic [1:0]             radix_code;
    logic                   overflowed;
    logic                   is_negative;

    modport source (
        output valid, output value, output is_valid, output radix_code,
        output overflowed, output is_negative, input ready
    );
    modport sink (
        input valid, input value, input is_valid, input radix_code,
        input overflowed, input is_negative, output ready
    );
endinterface

// ===== sv/ilp_char_step.sv =====
// Next parse state after one character of a literal.
module ilp_char_step (
    input  ilp_pkg::parse_state_t          cur,
    input  logic [ilp_pkg::CharWidth-1:0]  char_code,
    output ilp_pkg::parse_state_t          nxt
);
    import ilp_pkg::*;

    digit_t                digit;
    logic                  digit_ok;
    logic                  take_digit;
    logic                  set_radix;
    radix_t                new_radix;
    logic                  set_minus;
    logic                  flag_err;
    phase_t                phase_next;
    logic [AccWidth+3:0]   acc_ext;
    logic [AccWidth+3:0]   prod;

    assign digit    = digit_of(char_code);
    assign digit_ok = digit.hit && ({1'b0, digit.val} < radix_limit(cur.radix));

    // Phase transitions and the actions that each character triggers.
    always_comb
    begin
        take_digit = 1'b0;
        set_radix  = 1'b0;
        new_radix  = cur.radix;
        set_minus  = 1'b0;
        flag_err   = 1'b0;
        phase_next = cur.phase;
        if (!cur.err)
        begin
            case (cur.phase)
                PH_START, PH_SIGNED:
                begin
                    if (cur.phase == PH_START &&
                        (char_code == CharPlus || char_code == CharMinus))
                    begin
                        set_minus  = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else if (char_code == CharZero)
                    begin
                        phase_next = PH_LEAD_ZERO;
                    end
                    else if (digit.hit && digit.val < 4'd10)
                    begin
                        take_digit = 1'b1;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        flag_err = 1'b1;
                    end
                end
                PH_LEAD_ZERO:
                begin
                    if (char_code == CharLowerB)
                    begin
                        set_radix  = 1'b1;
                        new_radix  = RADIX_BIN;
                        phase_next = PH_NEED_DIGIT;
                    end
                    else if (char_code == CharLowerO)
                    begin
                        set_radix  = 1'b1;
                        new_radix  = RADIX_OCT;
                        phase_next = PH_NEED_DIGIT;
                    end
                    else if (char_code == CharLowerX)
                    begin
                        set_radix  = 1'b1;
                        new_radix  = RADIX_HEX;
                        phase_next = PH_NEED_DIGIT;
                    end
                    else if (char_code == CharUnderscore)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (digit_ok)
                    begin
                        take_digit = 1'b1;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        flag_err = 1'b1;
                    end
                end
                PH_NEED_DIGIT:
                begin
                    if (digit_ok)
                    begin
                        take_digit = 1'b1;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        flag_err = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (digit_ok)
                    begin
                        take_digit = 1'b1;
                    end
                    else if (char_code != CharUnderscore)
                    begin
                        flag_err = 1'b1;
                    end
                end
                default:
                begin
                    flag_err = 1'b1;
                end
            endcase
        end
    end

    // Accumulator update: a shift, or two shifts for decimal, plus the digit.
    // The four extra bits catch any carry past the accumulator width.
    always_comb
    begin
        acc_ext = {4'b0, cur.acc};
        case (cur.radix)
            RADIX_DEC: prod = (acc_ext << 3) + (acc_ext << 1) + {64'b0, digit.val};
            RADIX_BIN: prod = (acc_ext << 1) + {64'b0, digit.val};
            RADIX_OCT: prod = (acc_ext << 3) + {64'b0, digit.val};
            RADIX_HEX: prod = (acc_ext << 4) + {64'b0, digit.val};
            default:   prod = acc_ext;
        endcase

        nxt       = cur;
        nxt.phase = phase_next;
        nxt.err   = cur.err | flag_err;
        if (set_radix)
        begin
            nxt.radix = new_radix;
        end
        if (set_minus)
        begin
            nxt.minus = (char_code == CharMinus);
        end
        if (take_digit)
        begin
            nxt.acc  = prod[AccWidth-1:0];
            nxt.wrap = cur.wrap | (|prod[AccWidth+3:AccWidth]);
        end
    end

endmodule

// ===== sv/ilp_finish.sv =====
// Sign, width masking and overflow check of a finished literal.
module ilp_finish #(
    parameter int VALUE_WIDTH = ilp_pkg::ValueWidthDefault
) (
    input  ilp_pkg::parse_done_t     done,
    input  logic                     narrow,
    output logic [VALUE_WIDTH-1:0]   value,
    output logic                     is_valid,
    output logic [1:0]               radix_code,
    output logic                     overflowed,
    output logic                     is_negative
);
    import ilp_pkg::*;

    localparam logic [AccWidth-1:0] WideMask =
        (VALUE_WIDTH >= AccWidth) ? {AccWidth{1'b1}}
                                  : ((64'd1 << VALUE_WIDTH) - 64'd1);

    logic [AccWidth-1:0] mask;
    logic [AccWidth-1:0] signed_mag;
    logic [AccWidth-1:0] masked;

    // Two's complement negation after a minus sign, then cut to the width.
    always_comb
    begin
        mask       = narrow ? NarrowMask : WideMask;
        signed_mag = done.minus ? (64'd0 - done.mag) : done.mag;
        masked     = done.ok ? (signed_mag & mask) : '0;
    end

    // An invalid literal reports zero in every field.
    assign value       = masked[VALUE_WIDTH-1:0];
    assign is_valid    = done.ok;
    assign radix_code  = done.ok ? done.radix : RADIX_DEC;
    assign overflowed  = done.ok && (done.wrap || (|(done.mag & ~mask)));
    assign is_negative = done.ok && done.minus;

endmodule

// ===== sv/integer_literal_parser.sv =====
// Top level of the integer literal parser.
//
//  Channel   Direction  Contents
//  char_in   in         char_code, last_char (one character per transaction)
//  result_out out       value, is_valid, radix_code, overflowed, is_negative
//  cfg       in         cfg_wr_en, cfg_wr_data (narrow_result register)
//
// One character is taken every cycle while char_in is ready; the parse state
// is updated in the cycle of the transaction, so characters may follow each
// other back to back. After its final character a result passes the finish
// stage, holding the finished literal, then the output register, holding the
// signed and masked value. Reset clears the parse state and narrow_result.
// char_in stalls only while both stages hold results result_out has not taken.
module integer_literal_parser #(
    parameter int VALUE_WIDTH = ilp_pkg::ValueWidthDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    ilp_in_if.sink           char_in,
    ilp_out_if.source        result_out
);
    import ilp_pkg::*;

    parse_state_t            state_reg;
    parse_state_t            step_next;
    logic                    narrow_reg;
    logic                    fin_valid_reg;
    parse_done_t             fin_reg;
    parse_done_t             fin_next;
    logic                    out_valid_reg;
    logic [VALUE_WIDTH-1:0]  value_reg;
    logic [VALUE_WIDTH-1:0]  value_next;
    logic                    is_valid_reg;
    logic                    is_valid_next;
    logic [1:0]              radix_reg;
    logic [1:0]              radix_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic                    char_take;
    logic                    out_free;
    logic                    fin_move;

    // Flow control: the output register frees the finish stage, which frees input.
    assign out_free      = !out_valid_reg || result_out.ready;
    assign fin_move      = fin_valid_reg && out_free;
    assign char_in.ready = !fin_valid_reg || out_free;
    assign char_take     = char_in.valid && char_in.ready;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            narrow_reg <= cfg_wr_data;
        end
    end

    ilp_char_step u_step (
        .cur       (state_reg),
        .char_code (char_in.char_code),
        .nxt       (step_next)
    );

    // Summary of the literal as it stands after the current character.
    always_comb
    begin
        fin_next.ok    = !step_next.err &&
                         (step_next.phase == PH_LEAD_ZERO || step_next.phase == PH_BODY);
        fin_next.radix = step_next.radix;
        fin_next.minus = step_next.minus;
        fin_next.wrap  = step_next.wrap;
        fin_next.mag   = step_next.acc;
    end

    // Parse state; a final character returns it to the start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ParseIdle;
        end
        else if (char_take)
        begin
            state_reg <= char_in.last_char ? ParseIdle : step_next;
        end
    end

    // Finish stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (char_take && char_in.last_char)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (fin_move)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    // Finish stage payload.
    always_ff @(posedge clk)
    begin
        if (char_take && char_in.last_char)
        begin
            fin_reg <= fin_next;
        end
    end

    ilp_finish #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_finish (
        .done        (fin_reg),
        .narrow      (narrow_reg),
        .value       (value_next),
        .is_valid    (is_valid_next),
        .radix_code  (radix_next),
        .overflowed  (ovf_next),
        .is_negative (neg_next)
    );

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (fin_move)
        begin
            value_reg    <= value_next;
            is_valid_reg <= is_valid_next;
            radix_reg    <= radix_next;
            ovf_reg      <= ovf_next;
            neg_reg      <= neg_next;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.value       = ResultWidth'(value_reg);
    assign result_out.is_valid    = is_valid_reg;
    assign result_out.radix_code  = radix_reg;
    assign result_out.overflowed  = ovf_reg;
    assign result_out.is_negative = neg_reg;

endmodule

// ===== sv/ilp_checker.sv =====
// Port-level checks of the literal parser and their binding to the top level.
`include "assert_macros.svh"

module ilp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            in_last,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [ilp_pkg::ResultWidth-1:0] value,
    input  logic                            is_valid,
    input  logic [1:0]                      radix_code,
    input  logic                            overflowed,
    input  logic                            is_negative
);
    import ilp_pkg::*;

    // A rejected literal reports zero everywhere.
    `ASSERT_ALWAYS(a_invalid_zero, out_valid && !is_valid |-> value == '0 && radix_code == RADIX_DEC && !overflowed && !is_negative, "invalid result with nonzero fields")

    // A minus sign is only reported for a well-formed literal.
    `ASSERT_ALWAYS(a_neg_needs_valid, out_valid && is_negative |-> is_valid, "negative flag on invalid result")

    // A new result is preceded by an accepted final character, via the finish stage and the output register.
    `ASSERT_ALWAYS(a_result_after_last, $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2), "result without a final character")

    // A stalled result transaction keeps its payload.
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(is_valid) && $stable(radix_code) && $stable(overflowed) && $stable(is_negative), "stalled result changed")

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (char_in.valid),
    .in_ready    (char_in.ready),
    .in_last     (char_in.last_char),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .value       (result_out.value),
    .is_valid    (result_out.is_valid),
    .radix_code  (result_out.radix_code),
    .overflowed  (result_out.overflowed),
    .is_negative (result_out.is_negative)
);

// ===== test/tb_integer_literal_parser.sv =====
// Self-checking testbench for the integer literal parser.
`timescale 1ns / 100ps

module tb_integer_literal_parser;
    import ilp_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int DrainCycles  = 6;
    localparam int LongHold     = 200;
    localparam int PrintLimit   = 40;

    // Upper-case prefix letters, which the parser must refuse.
    localparam logic [7:0] CharUpperB = 8'h42;
    localparam logic [7:0] CharUpperO = 8'h4F;
    localparam logic [7:0] CharUpperX = 8'h58;

    typedef struct packed {
        logic [63:0] value;
        logic        is_valid;
        logic [1:0]  radix_code;
        logic        overflowed;
        logic        is_negative;
    } literal_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    ilp_in_if  char_if ();
    ilp_out_if result_if ();

    integer_literal_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .char_in     (char_if),
        .result_out  (result_if)
    );

    // Parse state of the literal in flight, as the predictor sees it.
    phase_t      lit_phase;
    radix_t      lit_radix;
    logic        lit_minus;
    logic [63:0] lit_acc;
    logic        lit_err;
    logic        lit_wrap;
    logic        narrow_mode;

    literal_result_t expected_results[$];
    logic [7:0]      literal_chars[$];

    int unsigned error_count;
    int unsigned cycle_count;
    bit          idle_on;
    bit          long_hold_req;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < PrintLimit)
            $display("mismatch in %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    function automatic int char_digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    function automatic int unsigned base_of(input radix_t r);
        case (r)
            RADIX_BIN: return 2;
            RADIX_OCT: return 8;
            RADIX_HEX: return 16;
            default:   return 10;
        endcase
    endfunction

    // Digit count that just fills 64 bits in each radix.
    function automatic int unsigned full_digits(input radix_t r);
        case (r)
            RADIX_BIN: return 64;
            RADIX_OCT: return 22;
            RADIX_HEX: return 16;
            default:   return 20;
        endcase
    endfunction

    function automatic void clear_literal();
        lit_phase = PH_START;
        lit_radix = RADIX_DEC;
        lit_minus = 1'b0;
        lit_acc   = '0;
        lit_err   = 1'b0;
        lit_wrap  = 1'b0;
    endfunction

    // Shift one digit into the magnitude, noting any carry past bit 63.
    function automatic void accumulate_digit(input int dv);
        logic [67:0] prod;
        logic [67:0] base;
        base = 68'(base_of(lit_radix));
        prod = 68'(lit_acc) * base + 68'(dv);
        if (prod[67:64] != 4'd0)
            lit_wrap = 1'b1;
        lit_acc = prod[63:0];
    endfunction

    // Advance the predicted parse by one accepted character.
    function automatic void predict_char(input logic [7:0] c, input logic last);
        int              dv;
        bit              fits;
        logic [63:0]     mask;
        literal_result_t res;
        dv   = char_digit_value(c);
        fits = (dv >= 0) && (dv < int'(base_of(lit_radix)));
        if (!lit_err)
        begin
            case (lit_phase)
                PH_START, PH_SIGNED:
                begin
                    if (lit_phase == PH_START && (c == CharPlus || c == CharMinus))
                    begin
                        lit_minus = (c == CharMinus);
                        lit_phase = PH_SIGNED;
                    end
                    else if (c == CharZero)
                        lit_phase = PH_LEAD_ZERO;
                    else if (fits)
                    begin
                        accumulate_digit(dv);
                        lit_phase = PH_BODY;
                    end
                    else
                        lit_err = 1'b1;
                end
                PH_LEAD_ZERO:
                begin
                    if (c == CharLowerB || c == CharLowerO || c == CharLowerX)
                    begin
                        lit_radix = (c == CharLowerB) ? RADIX_BIN :
                                    (c == CharLowerO) ? RADIX_OCT : RADIX_HEX;
                        lit_phase = PH_NEED_DIGIT;
                    end
                    else if (c == CharUnderscore)
                        lit_phase = PH_BODY;
                    else if (fits)
                    begin
                        accumulate_digit(dv);
                        lit_phase = PH_BODY;
                    end
                    else
                        lit_err = 1'b1;
                end
                PH_NEED_DIGIT:
                begin
                    if (fits)
                    begin
                        accumulate_digit(dv);
                        lit_phase = PH_BODY;
                    end
                    else
                        lit_err = 1'b1;
                end
                PH_BODY:
                begin
                    if (c != CharUnderscore)
                    begin
                        if (fits)
                            accumulate_digit(dv);
                        else
                            lit_err = 1'b1;
                    end
                end
                default:
                    lit_err = 1'b1;
            endcase
        end
        if (last)
        begin
            res  = '0;
            mask = narrow_mode ? NarrowMask : {64{1'b1}};
            if (!lit_err && (lit_phase == PH_LEAD_ZERO || lit_phase == PH_BODY))
            begin
                res.value       = (lit_minus ? (64'd0 - lit_acc) : lit_acc) & mask;
                res.is_valid    = 1'b1;
                res.radix_code  = lit_radix;
                res.overflowed  = lit_wrap || ((lit_acc & ~mask) != 64'd0);
                res.is_negative = lit_minus;
            end
            expected_results.push_back(res);
            clear_literal();
        end
    endfunction

    // Offer one character; valid stays high afterwards unless a gap follows.
    task automatic send_char(input logic [7:0] c, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        char_if.last_char <= last;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        predict_char(c, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_literal();
        foreach (literal_chars[i])
            send_char(literal_chars[i], i == literal_chars.size() - 1);
    endtask

    // Stop offering characters and wait until every result is in.
    task automatic drain_pipeline();
        char_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic set_narrow(input logic mode);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        narrow_mode = mode;
    endtask

    function automatic logic [7:0] digit_char(input int unsigned v, input bit upper);
        if (v < 10)
            return 8'(CharZero + v);
        return 8'((upper ? CharUpperA : CharLowerA) + v - 10);
    endfunction

    function automatic logic [7:0] prefix_char(input radix_t r, input bit upper);
        case (r)
            RADIX_BIN: return upper ? CharUpperB : CharLowerB;
            RADIX_OCT: return upper ? CharUpperO : CharLowerO;
            default:   return upper ? CharUpperX : CharLowerX;
        endcase
    endfunction

    // Mostly well-formed literals with random content; some noise and broken ones.
    function automatic void build_random_literal();
        int unsigned pick;
        int unsigned ndig;
        int unsigned top;
        int unsigned dval;
        int unsigned pos;
        radix_t      rad;
        bit          extreme;
        literal_chars.delete();
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            repeat ($urandom_range(1, 4))
                literal_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 2))
            1:       literal_chars.push_back(CharPlus);
            2:       literal_chars.push_back(CharMinus);
            default: ;
        endcase
        rad = radix_t'($urandom_range(0, 3));
        if (rad != RADIX_DEC)
        begin
            literal_chars.push_back(CharZero);
            literal_chars.push_back(prefix_char(rad, pick < 9));
        end
        top = base_of(rad);
        if ($urandom_range(0, 7) == 0)
            ndig = $urandom_range(full_digits(rad) - 2, full_digits(rad) + 3);
        else if (pick < 12)
            ndig = 0;
        else
            ndig = $urandom_range(1, 8);
        extreme = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < ndig; i++)
        begin
            if (extreme)
                dval = pick[0] ? top - 1 : 0;
            else
                dval = $urandom_range(0, top - 1);
            literal_chars.push_back(digit_char(dval, 1'($urandom_range(0, 1))));
            if ($urandom_range(0, 5) == 0)
                literal_chars.push_back(CharUnderscore);
        end
        if (literal_chars.size() == 0)
            literal_chars.push_back(CharZero);
        if (pick >= 12 && pick < 20)
        begin
            pos = $urandom_range(0, literal_chars.size() - 1);
            literal_chars[pos] = 8'($urandom_range(0, 255));
        end
    endfunction

    // Compare each result transaction against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        literal_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result_if.value, '0);
            else
            begin
                want = expected_results.pop_front();
                if (result_if.value !== want.value)
                    report_mismatch("value", result_if.value, want.value);
                if (result_if.is_valid !== want.is_valid)
                    report_mismatch("is_valid", 64'(result_if.is_valid), 64'(want.is_valid));
                if (result_if.radix_code !== want.radix_code)
                    report_mismatch("radix_code", 64'(result_if.radix_code),
                                    64'(want.radix_code));
                if (result_if.overflowed !== want.overflowed)
                    report_mismatch("overflowed", 64'(result_if.overflowed),
                                    64'(want.overflowed));
                if (result_if.is_negative !== want.is_negative)
                    report_mismatch("is_negative", 64'(result_if.is_negative),
                                    64'(want.is_negative));
            end
        end
    end

    // Result-side ready: random stall bursts, plus one long hold on request.
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_if.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Extremes of the character code, every radix and the malformed cases.
    task automatic test_directed();
        send_text("-0x7F");
        send_text("+0b1_");
        send_text("0o7");
        send_text("0O7");
        send_text("-");
        send_text("0x");
        send_text("0");
        send_char(8'hFF, 1'b1);
        send_char(8'h31, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h32, 1'b1);
    endtask

    task automatic test_random_literals(input int unsigned char_budget);
        int unsigned sent;
        sent = 0;
        while (sent < char_budget)
        begin
            build_random_literal();
            sent += literal_chars.size();
            send_literal();
        end
    endtask

    // Hold the result side off so the block fills and stalls its input.
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        repeat (40)
            send_char(8'(CharZero + $urandom_range(0, 9)), 1'b1);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = 1'b0;
        char_if.valid       = 1'b0;
        char_if.char_code   = '0;
        char_if.last_char   = 1'b0;
        error_count         = 0;
        cycle_count         = 0;
        idle_on             = 1'b1;
        long_hold_req       = 1'b0;
        narrow_mode         = 1'b0;
        clear_literal();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_narrow(1'b1);
        test_random_literals(400);
        set_narrow(1'b0);
        test_random_literals(500);
        test_backpressure();
        set_narrow(1'b1);
        idle_on = 1'b0;
        test_random_literals(350);

        drain_pipeline();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ilp_pkg.sv
sv/ilp_in_if.sv
sv/ilp_out_if.sv
sv/ilp_char_step.sv
sv/ilp_finish.sv
sv/integer_literal_parser.sv
sv/ilp_checker.sv
test/tb_integer_literal_parser.sv
